### src/epsd_pkg.sv
// Shared constants, state codes and month-length table for the epoch-to-date unit.
package epsd_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned BaseYear    = 1970;
	localparam int unsigned YearLen     = 365;
	localparam int unsigned LeapYearLen = 366;

	// 1970 = 19 centuries + 70 years; 19 mod 4 = 3
	localparam int unsigned BaseYearMod100 = BaseYear % 100;
	localparam int unsigned BaseCentMod4   = (BaseYear / 100) % 4;

	localparam int unsigned AccW  = 18;  // holds up to 2*86400-1
	localparam int unsigned YearW = 12;

	localparam logic [3:0] MonFeb = 4'd1;
	localparam logic [3:0] MonDec = 4'd11;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_HOUR = 7'b0000100,
		ST_MIN  = 7'b0001000,
		ST_YEAR = 7'b0010000,
		ST_MON  = 7'b0100000,
		ST_DONE = 7'b1000000
	} epsd_state_t;

	// days in month, month index 0 is January
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### src/epoch_seconds_to_date_unit.sv
// Top level: converts a 32-bit epoch second count into calendar date and time of day.
//
// Usage:
//  - Command channel: drive seconds_count and pulse start while busy is low; the word is
//    taken at that clock edge and busy rises on the next cycle.
//  - Result channel: year, month, day, hour, minute and second are valid while done is high;
//    done is high for a single cycle. The receiver cannot stall.
//  - Result fields stay held after done until the next command is accepted.
//
// One command at a time: a new command can be accepted in the cycle done is high.
//
// Every subtract-and-compare step goes through one shared 18-bit unit under a small sequencer:
//  - 32 restoring division steps by 86400 (days and second-of-day),
//  - 5 restoring steps for the hour, 6 for the minute, remainder is the second,
//  - whole years subtracted one at a time (365/366), leap rule tracked by mod-100 and
//    century-mod-4 counters that step with the year,
//  - whole months subtracted one at a time.
//
// Reset (arst_n low, asynchronous) returns the sequencer to idle; busy and done go low.
module epoch_seconds_to_date_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [31:0]                   seconds_count,
	output logic                          done,
	output logic [epsd_pkg::YearW-1:0]    year,
	output logic [3:0]                    month,
	output logic [4:0]                    day,
	output logic [4:0]                    hour,
	output logic [5:0]                    minute,
	output logic [5:0]                    second
);
	import epsd_pkg::*;

	epsd_state_t          state_q;
	logic [4:0]           cnt_q;        // bit/step counter
	logic [31:0]          sec_q;        // dividend shifts out, day quotient shifts in
	logic [AccW-1:0]      acc_q;        // working remainder / day count
	logic [YearW-1:0]     year_q;
	logic [6:0]           ymod100_q;    // year mod 100
	logic [1:0]           cent4_q;      // (year / 100) mod 4
	logic [3:0]           mon_q;        // 0-based month
	logic [4:0]           hour_q;
	logic [5:0]           minute_q;
	logic [5:0]           second_q;
	logic [4:0]           day_q;
	logic                 done_q;

	// shared subtract/compare unit
	logic [AccW-1:0]      op_a;
	logic [AccW-1:0]      op_b;
	logic [AccW:0]        diff;
	logic                 ge;
	logic                 leap;
	logic [AccW-1:0]      res;          // restoring result: diff if it fit, else a

	assign leap = (year_q[1:0] == 2'b00) && ((ymod100_q != 7'd0) || (cent4_q == 2'd0));

	always_comb begin
		op_a = acc_q;
		op_b = AccW'(SecsPerDay);
		case (state_q)
			ST_DIV:  begin
				op_a = {acc_q[AccW-2:0], sec_q[31]};
				op_b = AccW'(SecsPerDay);
			end
			ST_HOUR: op_b = AccW'(SecsPerHour) << cnt_q[2:0];
			ST_MIN:  op_b = AccW'(SecsPerMin) << cnt_q[2:0];
			ST_YEAR: op_b = leap ? AccW'(LeapYearLen) : AccW'(YearLen);
			ST_MON:  op_b = AccW'(month_len(mon_q, leap));
			default: op_b = AccW'(SecsPerDay);
		endcase
	end

	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign ge   = ~diff[AccW];
	assign res  = ge ? diff[AccW-1:0] : op_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						cnt_q   <= 5'd31;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_HOUR;
						cnt_q   <= 5'd4;
					end
				end
				ST_HOUR: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_MIN;
						cnt_q   <= 5'd5;
					end
				end
				ST_MIN: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!ge) begin
						state_q <= ST_MON;
					end
				end
				ST_MON: begin
					if (!ge || mon_q == MonDec) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sec_q     <= seconds_count;
					acc_q     <= '0;
					year_q    <= YearW'(BaseYear);
					ymod100_q <= 7'(BaseYearMod100);
					cent4_q   <= 2'(BaseCentMod4);
					mon_q     <= '0;
				end
			end
			ST_DIV: begin
				acc_q <= res;
				sec_q <= {sec_q[30:0], ge};
			end
			ST_HOUR: begin
				acc_q  <= res;
				hour_q <= {hour_q[3:0], ge};
			end
			ST_MIN: begin
				minute_q <= {minute_q[4:0], ge};
				if (cnt_q == 5'd0) begin
					// last minute step: leftover is the second, then load day count
					second_q <= res[5:0];
					acc_q    <= AccW'(sec_q[15:0]);
				end else begin
					acc_q <= res;
				end
			end
			ST_YEAR: begin
				if (ge) begin
					acc_q  <= res;
					year_q <= year_q + YearW'(1);
					if (ymod100_q == 7'd99) begin
						ymod100_q <= '0;
						cent4_q   <= cent4_q + 2'd1;
					end else begin
						ymod100_q <= ymod100_q + 7'd1;
					end
				end
			end
			ST_MON: begin
				if (ge && mon_q != MonDec) begin
					acc_q <= res;
					mon_q <= mon_q + 4'd1;
				end
			end
			ST_DONE: begin
				day_q <= acc_q[4:0] + 5'd1;
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign year   = year_q;
	assign month  = mon_q + 4'd1;
	assign day    = day_q;
	assign hour   = hour_q;
	assign minute = minute_q;
	assign second = second_q;

endmodule

### tb/epoch_seconds_to_date_unit_tb.sv
// Self-checking testbench for the epoch-seconds to calendar date/time unit.
module epoch_seconds_to_date_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import epsd_pkg::*;

	// The tail wait outlasts the longest accept-to-done, so stray words still show up.
	localparam int unsigned TailCycles    = 200;
	// No word moving for this long means the unit is hung.
	localparam int unsigned WatchdogLimit = 4000;
	localparam int unsigned RandWords     = 1200;
	localparam int unsigned ReportLimit   = 10;
	localparam int unsigned LeapFebDays   = 29;

	localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Sender idle percentage per random phase: light, heavy, none.
	localparam int unsigned PhaseGap [3] = '{23, 81, 0};

	// Directed counts: both ends of the range, unit boundaries of the time of day,
	// month and year edges, leap Feb 29 and Dec 31, century rules at 2000 and 2100,
	// and the 31-bit rollover.
	localparam logic [31:0] EdgeSecs [22] = '{
		32'd0,          32'd1,          32'd59,         32'd60,
		32'd3599,       32'd3600,       32'd86399,      32'd86400,
		32'd5097600,    32'd68169600,   32'd94608000,   32'd94694399,
		32'd94694400,   32'd951782400,  32'd978264000,  32'd1104537599,
		32'd4102444799, 32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF,
		32'h8000_0000,  32'hFFFF_FFFF
	};

	typedef struct {
		logic [31:0]      secs;
		logic [YearW-1:0] year;
		logic [3:0]       month;
		logic [4:0]       day;
		logic [4:0]       hour;
		logic [5:0]       minute;
		logic [5:0]       second;
	} date_word_t;

	// One pending command word plus how the sender should launch it.
	typedef struct {
		logic [31:0] secs;
		int unsigned gap_pct;  // chance per cycle of idling once the unit is free
		bit          early;    // raise start while the unit is still busy
		bit          drain;    // hold off until every expected date has come back
	} launch_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [31:0] seconds_count = '0;
	logic        busy;
	logic        done;
	logic [YearW-1:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	launch_t     cmd_q [$];
	date_word_t  date_q [$];
	int unsigned bad_words = 0;
	int unsigned quiet_cycles = 0;

	epoch_seconds_to_date_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.seconds_count (seconds_count),
		.done          (done),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	always #4 clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Calendar prediction: strip whole years from 1970, then whole months.
	function automatic date_word_t calendar_of(input logic [31:0] secs);
		date_word_t  w;
		int unsigned days;
		int unsigned sod;
		int unsigned yr;
		int unsigned mo;
		int unsigned span;
		days = secs / SecsPerDay;
		sod  = secs % SecsPerDay;
		yr   = BaseYear;
		mo   = 0;
		forever begin
			span = is_leap(yr) ? LeapYearLen : YearLen;
			if (days < span)
				break;
			days -= span;
			yr++;
		end
		while (mo < MonDec) begin
			span = MonthDays[mo];
			if (mo == MonFeb && is_leap(yr))
				span = LeapFebDays;
			if (days < span)
				break;
			days -= span;
			mo++;
		end
		w.secs   = secs;
		w.year   = YearW'(yr);
		w.month  = 4'(mo + 1);
		w.day    = 5'(days + 1);
		w.hour   = 5'(sod / SecsPerHour);
		w.minute = 6'((sod % SecsPerHour) / SecsPerMin);
		w.second = 6'(sod % SecsPerMin);
		return w;
	endfunction

	// Random count that lands on a month or year edge of a random year, random time of day.
	function automatic logic [31:0] near_calendar_edge();
		int unsigned yr;
		int unsigned days;
		int unsigned offs;
		int unsigned span;
		logic [63:0] total;
		int unsigned day_offs [10] = '{0, 30, 31, 58, 59, 60, 333, 334, 364, 365};
		yr   = $urandom_range(2105, BaseYear);
		days = 0;
		for (int unsigned y = BaseYear; y < yr; y++)
			days += is_leap(y) ? LeapYearLen : YearLen;
		span = is_leap(yr) ? LeapYearLen : YearLen;
		offs = day_offs[$urandom_range(9)];
		if (offs >= span)
			offs = span - 1;
		total = 64'(days + offs) * SecsPerDay + $urandom_range(SecsPerDay - 1);
		return total[31:0];
	endfunction

	task automatic queue_word(input logic [31:0] secs, input int unsigned gap_pct,
	                          input bit early, input bit drain);
		launch_t c;
		c.secs    = secs;
		c.gap_pct = gap_pct;
		c.early   = early;
		c.drain   = drain;
		cmd_q.push_back(c);
	endtask

	task automatic note_failure(input string msg);
		bad_words++;
		if (bad_words <= ReportLimit)
			$display("%s", msg);
	endtask

	// Driver: record the expected date on every accepted word, then pick what start
	// and seconds_count do next. At most one nonblocking write per signal per edge.
	always @(posedge clk) begin
		bit      took;
		bit      go;
		bit      fresh;
		launch_t nxt;
		took  = start && !busy;
		go    = 1'b0;
		fresh = 1'b0;
		if (took)
			date_q.push_back(calendar_of(seconds_count));
		if (start && !took) begin
			go = 1'b1;  // keep the word up until the unit takes it
		end else if (arst_n && cmd_q.size() != 0) begin
			nxt = cmd_q[0];
			// A drain word goes only once nothing is outstanding; a result leaving
			// on this edge counts as gone whichever block saw it first.
			if (nxt.drain)
				go = !took && (date_q.size() == 0 || (date_q.size() == 1 && done));
			else
				go = 1'b1;
			if (go)
				go = (busy || took) ? nxt.early : ($urandom_range(99) >= nxt.gap_pct);
			fresh = go;
		end
		if (fresh) begin
			seconds_count <= cmd_q[0].secs;
			cmd_q.delete(0);
		end else if (!go) begin
			seconds_count <= $urandom();  // junk while start is low must be ignored
		end
		start <= go;
	end

	// Monitor: every done strobe is matched against the oldest expected date.
	// Also the watchdog: counts cycles in which no word moves either way.
	always @(posedge clk) begin
		date_word_t want;
		if (arst_n && done) begin
			if (date_q.size() == 0) begin
				note_failure($sformatf("stray result %0d-%0d-%0d %0d:%0d:%0d",
					year, month, day, hour, minute, second));
			end else begin
				want = date_q.pop_front();
				if (year !== want.year || month !== want.month || day !== want.day ||
				    hour !== want.hour || minute !== want.minute ||
				    second !== want.second)
					note_failure($sformatf(
						"mismatch at %0d s: want %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
						want.secs, want.year, want.month, want.day, want.hour,
						want.minute, want.second, year, month, day, hour, minute, second));
			end
		end
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		foreach (EdgeSecs[i])
			queue_word(EdgeSecs[i], 0, 1'($urandom_range(1)), i == 0);
		// Random phases: a quarter of the words sit on calendar edges, the rest are
		// uniform over 32 bits. Each phase opens with a full drain.
		for (int p = 0; p < 3; p++) begin
			for (int unsigned i = 0; i < RandWords / 3; i++)
				queue_word(($urandom_range(3) == 0) ? near_calendar_edge() : $urandom(),
					PhaseGap[p], (p == 2) ? 1'b1 : 1'($urandom_range(1)),
					(i == 0) || ($urandom_range(49) == 0));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (cmd_q.size() != 0 || start);
		do @(negedge clk); while (date_q.size() != 0);
		repeat (TailCycles) @(negedge clk);

		if (bad_words == 0 && date_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
src/epsd_pkg.sv
src/epoch_seconds_to_date_unit.sv
tb/epoch_seconds_to_date_unit_tb.sv
